// ===== hdl/mgwg_pkg.sv =====
`timescale 1ns / 1ps

package mgwg_pkg;

  // Grid limits and derived widths
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int SIZE_W    = 7;
  localparam int WEIGHT_W  = 6;
  localparam int LOAD_ROWS = 3;

  // Input item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // Register indexes (byte address bit 2)
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  typedef enum logic [1:0] {
    REC_VERTEX = 2'd0,
    REC_HEDGE  = 2'd1,
    REC_VEDGE  = 2'd2
  } rec_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      start_eval;
    logic      wr_row;
    logic      rd_issue;
    logic      shift;
    logic      h_step;
    logic      emit;
    rec_kind_e emit_kind;
    logic      emit_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic node;
    logic h_open;
    logic v_open;
    logic h_cont;
    logic v_cont;
    logic out_ready;
  } dp_sts_t;

  // Open bit of a row at a column; columns with the top bit set are outside
  function automatic logic cell_at(input logic [MAX_COLS-1:0] row, input logic [COL_W:0] x);
    cell_at = x[COL_W] ? 1'b0 : row[x[COL_W-1:0]];
  endfunction

  // Straight corridor: open on exactly two opposite sides
  function automatic logic is_corridor(input logic up, input logic dn, input logic lf,
                                       input logic rt);
    is_corridor = (!up && !dn && lf && rt) || (up && dn && !lf && !rt);
  endfunction

endpackage

// ===== hdl/maze_grid_to_weighted_graph.sv =====
`timescale 1ns / 1ps
// Maze grid to weighted graph.
// Input channel (in_valid_i / in_stall_o): kind_i = 0 writes row_bits_i (1 = wall) into
// row row_index_i of the store with no result. kind_i = 1 evaluates cell
// (row_index_i, col_index_i) and yields 0 to 3 result items on the output channel
// (out_valid_o / out_stall_i): a vertex, then a horizontal edge, then a vertical edge,
// last_o marking the final one. Walls and non-node cells yield nothing.
// The block takes one item at a time; in_stall_o is high while an evaluation runs.
// Evaluation steps: take the item, fetch the rows above, at and below the cell (one
// store read port, registered read), test the node, walk the horizontal corridor one
// column at a time and stop, walk the vertical corridor row by row including the end
// row (fetch, window shift, test), and push each result.
// Results sit in an output register; while a result there is stalled the controller
// waits in its emit state with the next result, though the walks do not pause.
// Reset clears the controller and the output valid and sets grid_rows and grid_cols to
// 64; the row store holds no defined contents until rows are written. Size registers
// live on the APB port at byte addresses 0 and 4; the user must write them only
// while idle, as the block does not enforce it.
module maze_grid_to_weighted_graph (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [mgwg_pkg::ROW_W-1:0]    row_index_i,
  input  logic [mgwg_pkg::COL_W-1:0]    col_index_i,
  input  logic [mgwg_pkg::MAX_COLS-1:0] row_bits_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    record_kind_o,
  output logic [mgwg_pkg::ROW_W-1:0]    from_row_o,
  output logic [mgwg_pkg::COL_W-1:0]    from_col_o,
  output logic [mgwg_pkg::ROW_W-1:0]    to_row_o,
  output logic [mgwg_pkg::COL_W-1:0]    to_col_o,
  output logic [mgwg_pkg::WEIGHT_W-1:0] weight_o,
  output logic                          last_o
);

  logic [mgwg_pkg::SIZE_W-1:0] grid_rows_q, grid_cols_q;
  logic [mgwg_pkg::SIZE_W-1:0] eff_rows, eff_cols;
  logic                        cfg_wr;
  mgwg_pkg::dp_cmd_t           cmd;
  mgwg_pkg::dp_sts_t           sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= mgwg_pkg::SIZE_W'(mgwg_pkg::MAX_ROWS);
      grid_cols_q <= mgwg_pkg::SIZE_W'(mgwg_pkg::MAX_COLS);
    end else if (cfg_wr) begin
      if (paddr[2] == mgwg_pkg::REG_GRID_ROWS) begin
        grid_rows_q <= pwdata[mgwg_pkg::SIZE_W-1:0];
      end else begin
        grid_cols_q <= pwdata[mgwg_pkg::SIZE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == mgwg_pkg::REG_GRID_COLS) ? 32'(grid_cols_q) : 32'(grid_rows_q);

  // Sizes clamped to the store
  assign eff_rows = (grid_rows_q > mgwg_pkg::SIZE_W'(mgwg_pkg::MAX_ROWS))
                  ? mgwg_pkg::SIZE_W'(mgwg_pkg::MAX_ROWS) : grid_rows_q;
  assign eff_cols = (grid_cols_q > mgwg_pkg::SIZE_W'(mgwg_pkg::MAX_COLS))
                  ? mgwg_pkg::SIZE_W'(mgwg_pkg::MAX_COLS) : grid_cols_q;

  mgwg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mgwg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .eff_rows_i    (eff_rows),
    .eff_cols_i    (eff_cols),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .row_bits_i    (row_bits_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .record_kind_o (record_kind_o),
    .from_row_o    (from_row_o),
    .from_col_o    (from_col_o),
    .to_row_o      (to_row_o),
    .to_col_o      (to_col_o),
    .weight_o      (weight_o),
    .last_o        (last_o)
  );

endmodule

// ===== hdl/mgwg_datapath.sv =====
`timescale 1ns / 1ps

module mgwg_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mgwg_pkg::dp_cmd_t                 cmd_i,
  output mgwg_pkg::dp_sts_t                 sts_o,
  input  logic [mgwg_pkg::SIZE_W-1:0]       eff_rows_i,
  input  logic [mgwg_pkg::SIZE_W-1:0]       eff_cols_i,
  input  logic [mgwg_pkg::ROW_W-1:0]        row_index_i,
  input  logic [mgwg_pkg::COL_W-1:0]        col_index_i,
  input  logic [mgwg_pkg::MAX_COLS-1:0]     row_bits_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [1:0]                        record_kind_o,
  output logic [mgwg_pkg::ROW_W-1:0]        from_row_o,
  output logic [mgwg_pkg::COL_W-1:0]        from_col_o,
  output logic [mgwg_pkg::ROW_W-1:0]        to_row_o,
  output logic [mgwg_pkg::COL_W-1:0]        to_col_o,
  output logic [mgwg_pkg::WEIGHT_W-1:0]     weight_o,
  output logic                              last_o
);

  localparam logic [mgwg_pkg::COL_W:0] ONE_C = 1;
  localparam logic [mgwg_pkg::ROW_W:0] ONE_R = 1;
  localparam logic [mgwg_pkg::ROW_W:0] TWO_R = 2;

  // Row store, one word per maze row
  logic [mgwg_pkg::MAX_COLS-1:0] mem [mgwg_pkg::MAX_ROWS];

  logic [mgwg_pkg::ROW_W-1:0]    r_q;
  logic [mgwg_pkg::COL_W-1:0]    c_q;
  logic [mgwg_pkg::COL_W:0]      x_q;
  logic [mgwg_pkg::ROW_W:0]      rd_row_q;
  logic [mgwg_pkg::MAX_COLS-1:0] rd_data_q;
  logic                          rd_ok_q;
  logic [mgwg_pkg::MAX_COLS-1:0] up_q, mid_q, dn_q;
  logic [mgwg_pkg::MAX_COLS-1:0] col_mask;

  logic                          out_valid_q;
  logic [1:0]                    kind_q;
  logic [mgwg_pkg::ROW_W-1:0]    from_row_q;
  logic [mgwg_pkg::COL_W-1:0]    from_col_q;
  logic [mgwg_pkg::ROW_W-1:0]    to_row_q;
  logic [mgwg_pkg::COL_W-1:0]    to_col_q;
  logic [mgwg_pkg::WEIGHT_W-1:0] weight_q;
  logic                          last_q;

  logic [mgwg_pkg::ROW_W-1:0]    to_row_d;
  logic [mgwg_pkg::COL_W-1:0]    to_col_d;
  logic [mgwg_pkg::WEIGHT_W-1:0] weight_d;

  logic [mgwg_pkg::COL_W:0]      c7;
  logic [mgwg_pkg::ROW_W:0]      mid_row;
  logic [mgwg_pkg::COL_W:0]      h_diff;
  logic [mgwg_pkg::ROW_W:0]      v_diff;
  logic                          cur_open, cur_corr, x_open, x_corr;

  // Row write and row fetch
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_row) begin
      mem[row_index_i] <= row_bits_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_row_q[mgwg_pkg::ROW_W-1:0]];
      rd_ok_q   <= mgwg_pkg::SIZE_W'(rd_row_q) < eff_rows_i;
    end
  end

  // Columns in use
  always_comb begin
    for (int i = 0; i < mgwg_pkg::MAX_COLS; i++) begin
      col_mask[i] = mgwg_pkg::SIZE_W'(i) < eff_cols_i;
    end
  end

  // Cell position, walk pointers and the three-row window of open bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_eval) begin
      r_q      <= row_index_i;
      c_q      <= col_index_i;
      x_q      <= {1'b0, col_index_i} + ONE_C;
      rd_row_q <= {1'b0, row_index_i} - ONE_R;
    end else begin
      if (cmd_i.rd_issue) begin
        rd_row_q <= rd_row_q + ONE_R;
      end
      if (cmd_i.h_step) begin
        x_q <= x_q + ONE_C;
      end
    end
    if (cmd_i.shift) begin
      up_q  <= mid_q;
      mid_q <= dn_q;
      dn_q  <= rd_ok_q ? (~rd_data_q & col_mask) : '0;
    end
  end

  // Cell tests on the window
  always_comb begin
    c7       = {1'b0, c_q};
    cur_open = mgwg_pkg::cell_at(mid_q, c7);
    cur_corr = mgwg_pkg::is_corridor(mgwg_pkg::cell_at(up_q, c7), mgwg_pkg::cell_at(dn_q, c7),
                                     mgwg_pkg::cell_at(mid_q, c7 - ONE_C),
                                     mgwg_pkg::cell_at(mid_q, c7 + ONE_C));
    x_open   = mgwg_pkg::cell_at(mid_q, x_q);
    x_corr   = mgwg_pkg::is_corridor(mgwg_pkg::cell_at(up_q, x_q), mgwg_pkg::cell_at(dn_q, x_q),
                                     mgwg_pkg::cell_at(mid_q, x_q - ONE_C),
                                     mgwg_pkg::cell_at(mid_q, x_q + ONE_C));
    sts_o.node      = cur_open && !cur_corr;
    sts_o.v_cont    = cur_open && cur_corr;
    sts_o.h_open    = mgwg_pkg::cell_at(mid_q, c7 + ONE_C);
    sts_o.v_open    = mgwg_pkg::cell_at(dn_q, c7);
    sts_o.h_cont    = x_open && x_corr;
    sts_o.out_ready = !out_valid_q || !out_stall_i;
  end

  // Result fields by record kind; the middle window row trails the fetch pointer by two
  always_comb begin
    mid_row = rd_row_q - TWO_R;
    h_diff  = x_q - c7;
    v_diff  = mid_row - {1'b0, r_q};
    unique case (cmd_i.emit_kind)
      mgwg_pkg::REC_HEDGE: begin
        to_row_d = r_q;
        to_col_d = x_q[mgwg_pkg::COL_W-1:0];
        weight_d = mgwg_pkg::WEIGHT_W'(h_diff);
      end
      mgwg_pkg::REC_VEDGE: begin
        to_row_d = mid_row[mgwg_pkg::ROW_W-1:0];
        to_col_d = c_q;
        weight_d = mgwg_pkg::WEIGHT_W'(v_diff);
      end
      default: begin
        to_row_d = r_q;
        to_col_d = c_q;
        weight_d = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Node position is held with the item so a new evaluation cannot disturb it
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q     <= cmd_i.emit_kind;
      from_row_q <= r_q;
      from_col_q <= c_q;
      to_row_q   <= to_row_d;
      to_col_q   <= to_col_d;
      weight_q   <= weight_d;
      last_q     <= cmd_i.emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = kind_q;
  assign from_row_o    = from_row_q;
  assign from_col_o    = from_col_q;
  assign to_row_o      = to_row_q;
  assign to_col_o      = to_col_q;
  assign weight_o      = weight_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/mgwg_ctrl.sv =====
`timescale 1ns / 1ps

module mgwg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              kind_i,
  output logic              in_stall_o,
  input  mgwg_pkg::dp_sts_t sts_i,
  output mgwg_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_FETCH   = 9'b000000010,
    ST_SHIFT   = 9'b000000100,
    ST_NODE    = 9'b000001000,
    ST_EMIT_VX = 9'b000010000,
    ST_HWALK   = 9'b000100000,
    ST_EMIT_H  = 9'b001000000,
    ST_VWALK   = 9'b010000000,
    ST_EMIT_V  = 9'b100000000
  } state_e;

  localparam logic [1:0] LOAD_LAST = 2'(mgwg_pkg::LOAD_ROWS - 1);

  state_e     state_q, state_d;
  logic       vmode_q, vmode_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vmode_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      vmode_q <= vmode_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    vmode_d = vmode_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == mgwg_pkg::KIND_EVAL) begin
            cmd_o.start_eval = 1'b1;
            vmode_d          = 1'b0;
            cnt_d            = '0;
            state_d          = ST_FETCH;
          end else begin
            cmd_o.wr_row = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (vmode_q) begin
          state_d = ST_VWALK;
        end else if (cnt_q == LOAD_LAST) begin
          state_d = ST_NODE;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = ST_FETCH;
        end
      end
      ST_NODE: begin
        state_d = sts_i.node ? ST_EMIT_VX : ST_IDLE;
      end
      ST_EMIT_VX: begin
        if (sts_i.out_ready) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = mgwg_pkg::REC_VERTEX;
          cmd_o.emit_last = !sts_i.h_open && !sts_i.v_open;
          if (sts_i.h_open) begin
            state_d = ST_HWALK;
          end else if (sts_i.v_open) begin
            vmode_d = 1'b1;
            state_d = ST_FETCH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      // one column per cycle along the node's row
      ST_HWALK: begin
        if (sts_i.h_cont) begin
          cmd_o.h_step = 1'b1;
        end else begin
          state_d = ST_EMIT_H;
        end
      end
      ST_EMIT_H: begin
        if (sts_i.out_ready) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = mgwg_pkg::REC_HEDGE;
          cmd_o.emit_last = !sts_i.v_open;
          if (sts_i.v_open) begin
            vmode_d = 1'b1;
            state_d = ST_FETCH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      // one row per fetch/shift pair down the node's column
      ST_VWALK: begin
        state_d = sts_i.v_cont ? ST_FETCH : ST_EMIT_V;
      end
      ST_EMIT_V: begin
        if (sts_i.out_ready) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = mgwg_pkg::REC_VEDGE;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A result is only pushed into a free output slot
  a_emit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_ready)
    else $error("result pushed into a full output register");

  // An accepted evaluate item keeps the input stalled on the next cycle
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == mgwg_pkg::KIND_EVAL) |=> in_stall_o)
    else $error("evaluate item did not make the block busy");

  // A fetched row is always shifted into the window next
  a_fetch_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> cmd_o.shift)
    else $error("fetched row not shifted into the window");

  // The final result of a cell returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.emit_last) |=> !in_stall_o)
    else $error("block busy after the final result of a cell");

endmodule

// ===== tb/sv/maze_grid_to_weighted_graph_tb.sv =====
`timescale 1ns / 1ps

module maze_grid_to_weighted_graph_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // margin for the longest evaluation: a full vertical and horizontal walk plus overhead
  localparam int SETTLE_CYCLES = 3 * mgwg_pkg::MAX_ROWS + mgwg_pkg::MAX_COLS + 32;
  localparam int HOLD_CYCLES   = 400;

  // how a directed item's results are known
  typedef enum int {
    OUT_PREDICTED,
    OUT_NONE,
    OUT_VERTEX
  } outcome_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    mgwg_pkg::rec_kind_e                kind;
    logic [mgwg_pkg::ROW_W-1:0]         from_row;
    logic [mgwg_pkg::COL_W-1:0]         from_col;
    logic [mgwg_pkg::ROW_W-1:0]         to_row;
    logic [mgwg_pkg::COL_W-1:0]         to_col;
    logic [mgwg_pkg::WEIGHT_W-1:0]      weight;
    logic                               last;
  } graph_rec_t;

  typedef struct packed {
    logic                               kind;
    logic [mgwg_pkg::ROW_W-1:0]         row;
    logic [mgwg_pkg::COL_W-1:0]         col;
    logic [mgwg_pkg::MAX_COLS-1:0]      bits;
  } maze_item_t;

  typedef struct {
    logic                               kind;
    int                                 row;
    int                                 col;
    logic [mgwg_pkg::MAX_COLS-1:0]      bits;
    outcome_e                           outcome;
  } plan_row_t;

  typedef struct {
    int                                 rows;
    int                                 cols;
    int                                 count;
    idle_e                              idling;
    bit                                 rand_size;
  } phase_t;

  // DUT signals
  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               psel        = 1'b0;
  logic                               penable     = 1'b0;
  logic                               pwrite      = 1'b0;
  logic [2:0]                         paddr       = '0;
  logic [31:0]                        pwdata      = '0;
  logic [31:0]                        prdata;
  logic                               pready;
  logic                               in_valid_i  = 1'b0;
  logic                               in_stall_o;
  logic                               kind_i      = mgwg_pkg::KIND_WRITE;
  logic [mgwg_pkg::ROW_W-1:0]         row_index_i = '0;
  logic [mgwg_pkg::COL_W-1:0]         col_index_i = '0;
  logic [mgwg_pkg::MAX_COLS-1:0]      row_bits_i  = '1;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [1:0]                         record_kind_o;
  logic [mgwg_pkg::ROW_W-1:0]         from_row_o;
  logic [mgwg_pkg::COL_W-1:0]         from_col_o;
  logic [mgwg_pkg::ROW_W-1:0]         to_row_o;
  logic [mgwg_pkg::COL_W-1:0]         to_col_o;
  logic [mgwg_pkg::WEIGHT_W-1:0]      weight_o;
  logic                               last_o;

  // Shadow of the maze and the size registers
  logic [mgwg_pkg::MAX_COLS-1:0]      maze_rows [mgwg_pkg::MAX_ROWS];
  logic [mgwg_pkg::SIZE_W-1:0]        size_rows = 7'd64;
  logic [mgwg_pkg::SIZE_W-1:0]        size_cols = 7'd64;
  logic [mgwg_pkg::MAX_COLS-1:0]      prev_bits = '1;

  graph_rec_t              expected_recs [$];
  int unsigned             mismatch_cnt  = 0;
  int unsigned             cycle_cnt     = 0;
  int                      send_idle_pct = 0;
  int                      stall_pct     = 0;
  int                      hold_left     = 0;

  // Small maze in the top-left corner, a bottom border row, vertical corridors
  plan_row_t plan [23] = '{
    '{mgwg_pkg::KIND_WRITE, 0,  0,  64'hFFFF_FFFF_FFFF_FFF0, OUT_NONE},
    '{mgwg_pkg::KIND_WRITE, 1,  0,  64'hFFFF_FFFF_FFFF_FFF6, OUT_NONE},
    '{mgwg_pkg::KIND_WRITE, 2,  0,  64'hFFFF_FFFF_FFFF_FFF0, OUT_NONE},
    '{mgwg_pkg::KIND_EVAL,  0,  0,  64'h0,                   OUT_PREDICTED},
    '{mgwg_pkg::KIND_EVAL,  0,  1,  64'h0,                   OUT_NONE},
    '{mgwg_pkg::KIND_EVAL,  0,  3,  64'h0,                   OUT_PREDICTED},
    '{mgwg_pkg::KIND_EVAL,  2,  0,  64'h0,                   OUT_PREDICTED},
    '{mgwg_pkg::KIND_EVAL,  2,  3,  64'h0,                   OUT_VERTEX},
    '{mgwg_pkg::KIND_EVAL,  1,  1,  64'h0,                   OUT_NONE},
    '{mgwg_pkg::KIND_WRITE, 63, 63, 64'h7FFF_FFFF_FFFF_FFFE, OUT_NONE},
    '{mgwg_pkg::KIND_EVAL,  63, 63, 64'hFFFF_FFFF_FFFF_FFFF, OUT_VERTEX},
    '{mgwg_pkg::KIND_EVAL,  63, 0,  64'h0,                   OUT_VERTEX},
    '{mgwg_pkg::KIND_WRITE, 62, 0,  64'h0,                   OUT_NONE},
    '{mgwg_pkg::KIND_EVAL,  62, 0,  64'h0,                   OUT_PREDICTED},
    '{mgwg_pkg::KIND_EVAL,  62, 63, 64'h0,                   OUT_PREDICTED},
    '{mgwg_pkg::KIND_EVAL,  62, 30, 64'h0,                   OUT_NONE},
    '{mgwg_pkg::KIND_WRITE, 30, 0,  64'hAAAA_AAAA_AAAA_AAAA, OUT_NONE},
    '{mgwg_pkg::KIND_WRITE, 31, 0,  64'hAAAA_AAAA_AAAA_AAAA, OUT_NONE},
    '{mgwg_pkg::KIND_WRITE, 29, 0,  64'h0,                   OUT_NONE},
    '{mgwg_pkg::KIND_WRITE, 32, 0,  64'h0,                   OUT_NONE},
    '{mgwg_pkg::KIND_EVAL,  29, 0,  64'h0,                   OUT_PREDICTED},
    '{mgwg_pkg::KIND_EVAL,  31, 2,  64'h0,                   OUT_NONE},
    '{mgwg_pkg::KIND_EVAL,  30, 1,  64'h0,                   OUT_NONE}
  };

  // Random phases: sizes include the clamp and the all-wall cases
  phase_t phases [8] = '{
    '{64,  64,  50, IDLE_NONE, 1'b0},
    '{3,   3,   30, IDLE_SEND, 1'b0},
    '{127, 100, 45, IDLE_RECV, 1'b0},
    '{0,   9,   10, IDLE_BOTH, 1'b0},
    '{12,  0,   10, IDLE_NONE, 1'b0},
    '{0,   0,   45, IDLE_BOTH, 1'b1},
    '{40,  64,  45, IDLE_SEND, 1'b0},
    '{64,  17,  45, IDLE_RECV, 1'b0}
  };

  maze_grid_to_weighted_graph dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Graph predictor
  // ---------------------------------------------------------------------------
  function automatic int rows_in_use();
    return (size_rows > mgwg_pkg::MAX_ROWS) ? mgwg_pkg::MAX_ROWS : int'(size_rows);
  endfunction

  function automatic int cols_in_use();
    return (size_cols > mgwg_pkg::MAX_COLS) ? mgwg_pkg::MAX_COLS : int'(size_cols);
  endfunction

  // off-grid cells read as walls
  function automatic bit open_at(int r, int c);
    if (r < 0 || r >= rows_in_use() || c < 0 || c >= cols_in_use()) return 1'b0;
    return !maze_rows[r][c];
  endfunction

  function automatic bit straight_run(int r, int c);
    bit up, dn, lf, rt;
    up = open_at(r - 1, c);
    dn = open_at(r + 1, c);
    lf = open_at(r, c - 1);
    rt = open_at(r, c + 1);
    return (!up && !dn && lf && rt) || (up && dn && !lf && !rt);
  endfunction

  function automatic graph_rec_t make_rec(mgwg_pkg::rec_kind_e k, int fr, int fc, int tr,
                                          int tc, int w);
    graph_rec_t g;
    g.kind     = k;
    g.from_row = fr[mgwg_pkg::ROW_W-1:0];
    g.from_col = fc[mgwg_pkg::COL_W-1:0];
    g.to_row   = tr[mgwg_pkg::ROW_W-1:0];
    g.to_col   = tc[mgwg_pkg::COL_W-1:0];
    g.weight   = w[mgwg_pkg::WEIGHT_W-1:0];
    g.last     = 1'b0;
    return g;
  endfunction

  // Vertex, then edges that skip straight corridor cells
  function automatic void trace_node(int r, int c);
    graph_rec_t recs [$];
    int run;
    if (!open_at(r, c) || straight_run(r, c)) return;
    recs = {recs, make_rec(mgwg_pkg::REC_VERTEX, r, c, r, c, 0)};
    if (open_at(r, c + 1)) begin
      run = 0;
      while (open_at(r, c + run + 1) && straight_run(r, c + run + 1)) run++;
      recs = {recs, make_rec(mgwg_pkg::REC_HEDGE, r, c, r, c + run + 1, run + 1)};
    end
    if (open_at(r + 1, c)) begin
      run = 0;
      while (open_at(r + run + 1, c) && straight_run(r + run + 1, c)) run++;
      recs = {recs, make_rec(mgwg_pkg::REC_VEDGE, r, c, r + run + 1, c, run + 1)};
    end
    recs[$].last = 1'b1;
    expected_recs = {expected_recs, recs};
  endfunction

  function automatic void report(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    graph_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_recs.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected record, got kind %0d from (%0d,%0d) to (%0d,%0d) w %0d",
                 $time, record_kind_o, from_row_o, from_col_o, to_row_o, to_col_o,
                 weight_o);
      end else begin
        want = expected_recs.pop_front();
        report("record_kind", 8'(want.kind), 8'(record_kind_o));
        report("from_row", 8'(want.from_row), 8'(from_row_o));
        report("from_col", 8'(want.from_col), 8'(from_col_o));
        report("to_row", 8'(want.to_row), 8'(to_row_o));
        report("to_col", 8'(want.to_col), 8'(to_col_o));
        report("weight", 8'(want.weight), 8'(weight_o));
        report("last", 8'(want.last), 8'(last_o));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timed out", $time);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  task automatic reg_read_check(logic idx, logic [mgwg_pkg::SIZE_W-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    report("prdata", {1'b0, want}, prdata[7:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(logic idx, logic [mgwg_pkg::SIZE_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(32 - mgwg_pkg::SIZE_W){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == mgwg_pkg::REG_GRID_ROWS) size_rows = value;
    else size_cols = value;
    reg_read_check(idx, value);
  endtask

  // ---------------------------------------------------------------------------
  // Item driver
  // ---------------------------------------------------------------------------
  task automatic push_item(maze_item_t it, outcome_e how);
    graph_rec_t rec;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    kind_i      <= it.kind;
    row_index_i <= it.row;
    col_index_i <= it.col;
    row_bits_i  <= it.bits;
    do @(posedge clk_i); while (in_stall_o);
    // item taken at this edge
    if (it.kind == mgwg_pkg::KIND_WRITE) begin
      maze_rows[it.row] = it.bits;
    end else begin
      case (how)
        OUT_PREDICTED: trace_node(int'(it.row), int'(it.col));
        OUT_VERTEX: begin
          rec = make_rec(mgwg_pkg::REC_VERTEX, int'(it.row), int'(it.col), int'(it.row),
                         int'(it.col), 0);
          rec.last = 1'b1;
          expected_recs = {expected_recs, rec};
        end
        default: ;
      endcase
    end
  endtask

  // Stop sending, wait for all records, then let a late evaluation finish
  task automatic drain(int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Row patterns that build corridors; repeats stack into vertical runs
  function automatic logic [mgwg_pkg::MAX_COLS-1:0] maze_row_pattern();
    logic [mgwg_pkg::MAX_COLS-1:0] bits;
    logic [mgwg_pkg::MAX_COLS-1:0] run_mask;
    int lo, hi;
    if ($urandom_range(99) < 35) begin
      bits = prev_bits;
    end else begin
      case ($urandom_range(7))
        0: bits = {$urandom, $urandom};
        1: bits = '0;
        2: bits = '1;
        3: bits = {(mgwg_pkg::MAX_COLS / 2){2'b10}};
        4: bits = {(mgwg_pkg::MAX_COLS / 2){2'b01}};
        5: bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        6: bits = {$urandom, $urandom} | {$urandom, $urandom};
        default: begin
          // one open run between walls
          lo       = int'($urandom_range(mgwg_pkg::MAX_COLS - 1));
          hi       = int'($urandom_range(mgwg_pkg::MAX_COLS - 1, lo));
          run_mask = ((64'd1 << (hi - lo + 1)) - 64'd1) << lo;
          bits     = ~run_mask;
        end
      endcase
    end
    prev_bits = bits;
    return bits;
  endfunction

  task automatic random_item();
    maze_item_t it;
    int tries;
    if ($urandom_range(99) < 30) begin
      it.kind = mgwg_pkg::KIND_WRITE;
      it.col  = mgwg_pkg::COL_W'($urandom);
      it.bits = maze_row_pattern();
      if (rows_in_use() > 0 && $urandom_range(3) != 0)
        it.row = mgwg_pkg::ROW_W'($urandom_range(rows_in_use() - 1));
      else it.row = mgwg_pkg::ROW_W'($urandom_range(mgwg_pkg::MAX_ROWS - 1));
    end else begin
      it.kind = mgwg_pkg::KIND_EVAL;
      it.bits = {$urandom, $urandom};
      it.row  = mgwg_pkg::ROW_W'($urandom_range(mgwg_pkg::MAX_ROWS - 1));
      it.col  = mgwg_pkg::COL_W'($urandom_range(mgwg_pkg::MAX_COLS - 1));
      // mostly open cells inside the grid
      if (rows_in_use() > 0 && cols_in_use() > 0 && $urandom_range(99) < 85) begin
        for (tries = 0; tries < 8; tries++) begin
          it.row = mgwg_pkg::ROW_W'($urandom_range(rows_in_use() - 1));
          it.col = mgwg_pkg::COL_W'($urandom_range(cols_in_use() - 1));
          if (open_at(int'(it.row), int'(it.col))) break;
        end
      end
    end
    push_item(it, OUT_PREDICTED);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    maze_item_t it;
    int k;
    int rows_val;
    int cols_val;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sizes after reset
    reg_read_check(mgwg_pkg::REG_GRID_ROWS, 7'd64);
    reg_read_check(mgwg_pkg::REG_GRID_COLS, 7'd64);

    // fill every row with walls so no unwritten row is ever read
    for (k = 0; k < mgwg_pkg::MAX_ROWS; k++) begin
      it.kind = mgwg_pkg::KIND_WRITE;
      it.row  = k[mgwg_pkg::ROW_W-1:0];
      it.col  = '0;
      it.bits = '1;
      push_item(it, OUT_NONE);
    end

    // directed items
    foreach (plan[i]) begin
      it.kind = plan[i].kind;
      it.row  = plan[i].row[mgwg_pkg::ROW_W-1:0];
      it.col  = plan[i].col[mgwg_pkg::COL_W-1:0];
      it.bits = plan[i].bits;
      push_item(it, plan[i].outcome);
    end
    drain(SETTLE_CYCLES);

    // random phases
    foreach (phases[p]) begin
      rows_val = phases[p].rand_size ? int'($urandom_range(mgwg_pkg::MAX_ROWS, 3))
                                     : phases[p].rows;
      cols_val = phases[p].rand_size ? int'($urandom_range(mgwg_pkg::MAX_COLS, 3))
                                     : phases[p].cols;
      reg_write(mgwg_pkg::REG_GRID_ROWS, rows_val[mgwg_pkg::SIZE_W-1:0]);
      reg_write(mgwg_pkg::REG_GRID_COLS, cols_val[mgwg_pkg::SIZE_W-1:0]);
      case (phases[p].idling)
        IDLE_SEND: begin send_idle_pct = 78; stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 78; end
        IDLE_BOTH: begin send_idle_pct = 31; stall_pct = 31; end
        default:   begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      for (k = 0; k < phases[p].count; k++) begin
        // back up the output side while items keep coming
        if (p == 0 && k == 20) hold_left = HOLD_CYCLES;
        // sender waits for the pipeline to empty once
        if (p == 6 && k == 30) drain(0);
        random_item();
      end
      drain(SETTLE_CYCLES);
    end

    if (mismatch_cnt == 0 && expected_recs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_recs.size() != 0)
        $display("%0t: %0d records never arrived", $time, expected_recs.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
